@@ sv/rx_ring_with_rts_watermarks_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Receive ring assertion macros
// Shared concurrent assertion forms for the receive ring modules.
// ---------------------------------------------------------------------------
`ifndef RX_RING_WITH_RTS_WATERMARKS_UNIT_MACROS_SVH
`define RX_RING_WITH_RTS_WATERMARKS_UNIT_MACROS_SVH

// same-cycle implication, off while reset is high
`define RRW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error(msg);

// next-cycle implication, off while reset is high
`define RRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error(msg);

`endif

@@ sv/rrw_pkg.sv @@
// ---------------------------------------------------------------------------
// Receive ring package
// Types, codes and constants shared by the receive ring modules.
// ---------------------------------------------------------------------------
package rrw_pkg;

   localparam int RING_DEPTH_DEF = 128;

   localparam logic [7:0] PAIR_BYTE = 8'hFF;
   localparam logic [7:0] NEST_MAX  = 8'hFF;

   localparam logic [7:0] HIGH_WATER_RST = 8'd16;
   localparam logic [7:0] LOW_WATER_RST  = 8'd8;
   localparam logic       PORT_READY_RST = 1'b1;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REG_HIGH_WATER = 2'd0;
   localparam logic [1:0] REG_LOW_WATER  = 2'd1;
   localparam logic [1:0] REG_PORT_READY = 2'd2;

   typedef enum logic [1:0] {
      FUNC_RX      = 2'd0,
      FUNC_READ    = 2'd1,
      FUNC_HOLD    = 2'd2,
      FUNC_RELEASE = 2'd3
   } func_type;

   typedef struct packed {
      logic capture;
      logic exec_op;
      logic rd_issue;
      logic rd_first;
      logic rd_second;
      logic low_check;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     empty;
      logic     pair;
   } sts_type;

endpackage

@@ sv/rrw_ifs.sv @@
// ---------------------------------------------------------------------------
// Receive ring channel interfaces
// Valid/ready channels for request and response words.
// ---------------------------------------------------------------------------
interface rrw_req_if;
   logic              valid;
   logic              ready;
   rrw_pkg::func_type func;
   logic [7:0]        rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface rrw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       read_valid;
   logic       rts_asserted;
   logic [7:0] fill_level;
   logic       overflow;

   modport source (output valid, output read_byte, output read_valid,
                   output rts_asserted, output fill_level, output overflow,
                   input ready);
   modport sink   (input valid, input read_byte, input read_valid,
                   input rts_asserted, input fill_level, input overflow,
                   output ready);
endinterface

@@ sv/rrw_ram.sv @@
// ---------------------------------------------------------------------------
// Receive ring RAM
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rrw_pkg::RING_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/rrw_ctrl.sv @@
// ---------------------------------------------------------------------------
// Receive ring controller
// Sequences one word at a time through execute, ring read and output load.
// ---------------------------------------------------------------------------
`include "rx_ring_with_rts_watermarks_unit_macros.svh"

module rrw_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rrw_pkg::cmd_type cmd,
   input  rrw_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RD0,
      S_RD1,
      S_CHK,
      S_PUSH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.func == rrw_pkg::FUNC_READ) begin
               if (sts.empty) begin
                  state_in = S_CHK;
               end else begin
                  cmd.rd_issue = 1'b1;
                  state_in     = S_RD0;
               end
            end else begin
               cmd.exec_op = 1'b1;
               state_in    = S_PUSH;
            end
         end
         S_RD0: begin
            cmd.rd_first = 1'b1;
            state_in     = sts.pair ? S_RD1 : S_CHK;
         end
         S_RD1: begin
            cmd.rd_second = 1'b1;
            state_in      = S_CHK;
         end
         S_CHK: begin
            cmd.low_check = 1'b1;
            state_in      = S_PUSH;
         end
         S_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RRW_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_valid && req_ready, state_ff == S_EXEC, "accepted word did not enter execute")
   `RRW_ASSERT_IMP(a_rsp_from_push, clock, reset, !$past(reset) && $rose(rsp_valid_ff), $past(state_ff) == S_PUSH, "response raised outside push")
   `RRW_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid_ff && !rsp_ready, rsp_valid_ff, "response dropped while stalled")

endmodule

@@ sv/rrw_datapath.sv @@
// ---------------------------------------------------------------------------
// Receive ring datapath
// Ring pointers, hold nesting, RTS state, ring RAM and response register.
// ---------------------------------------------------------------------------
`include "rx_ring_with_rts_watermarks_unit_macros.svh"

module rrw_datapath #(
   parameter int RING_DEPTH = rrw_pkg::RING_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rrw_pkg::cmd_type  cmd,
   output rrw_pkg::sts_type  sts,
   input  rrw_pkg::func_type in_func,
   input  logic [7:0]        in_rx_byte,
   input  logic [7:0]        high_water,
   input  logic [7:0]        low_water,
   input  logic              port_ready,
   output logic [7:0]        out_read_byte,
   output logic              out_read_valid,
   output logic              out_rts,
   output logic [7:0]        out_fill,
   output logic              out_overflow
);

   localparam int AW    = $clog2(RING_DEPTH);
   localparam int CW    = $clog2(2 * RING_DEPTH);
   localparam int CMP_W = (CW > 8) ? CW : 8;
   localparam logic [CW-1:0] CNT_LAST = CW'(2 * RING_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);
   localparam logic [CW:0]   SPAN     = (CW + 1)'(2 * RING_DEPTH);

   function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] c);
      logic [CW-1:0] r;
      if (c == CNT_LAST) r = '0;
      else               r = c + 1'b1;
      return r;
   endfunction

   function automatic logic [AW-1:0] ring_idx(input logic [CW-1:0] c);
      logic [CW-1:0] r;
      if (c >= DEPTH_C) r = c - DEPTH_C;
      else              r = c;
      return r[AW-1:0];
   endfunction

   rrw_pkg::func_type func_ff;
   logic [7:0]        byte_ff;
   logic [CW-1:0]     head_ff, head_in;
   logic [CW-1:0]     tail_ff, tail_in;
   logic [7:0]        nest_ff, nest_in;
   logic              rts_ff, rts_in;
   logic [7:0]        rd_ff, rd_in;
   logic              valid_ff, valid_in;
   logic              ovf_ff, ovf_in;

   logic [7:0]        obyte_ff;
   logic              ovalid_ff;
   logic              orts_ff;
   logic [7:0]        ofill_ff;
   logic              oovf_ff;

   logic [CW-1:0]     fill;
   logic [CMP_W-1:0]  fill_cmp, fill_new_cmp;
   logic              full;
   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [7:0]        ram_rdata;

   always_comb begin
      if (tail_ff >= head_ff) fill = tail_ff - head_ff;
      else fill = CW'({1'b0, tail_ff} + SPAN - {1'b0, head_ff});
   end

   assign full         = fill >= DEPTH_C;
   assign fill_cmp     = CMP_W'(fill);
   assign fill_new_cmp = fill_cmp + CMP_W'(!full);

   assign sts.func  = func_ff;
   assign sts.empty = (fill == '0);
   assign sts.pair  = (ram_rdata == rrw_pkg::PAIR_BYTE) && (fill > CW'(1));

   assign ram_we    = cmd.exec_op && (func_ff == rrw_pkg::FUNC_RX) && !full;
   assign ram_re    = cmd.rd_issue || (cmd.rd_first && sts.pair);
   assign ram_raddr = cmd.rd_first ? ring_idx(cnt_inc(head_ff)) : ring_idx(head_ff);

   rrw_ram #(
      .WIDTH (8),
      .DEPTH (RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ring_idx(tail_ff)),
      .wr_data (byte_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      nest_in  = nest_ff;
      rts_in   = rts_ff;
      rd_in    = rd_ff;
      valid_in = valid_ff;
      ovf_in   = ovf_ff;
      if (cmd.capture) begin
         rd_in    = '0;
         valid_in = 1'b0;
         ovf_in   = 1'b0;
      end
      if (cmd.exec_op) begin
         case (func_ff)
            rrw_pkg::FUNC_RX: begin
               if (full) ovf_in  = 1'b1;
               else      tail_in = cnt_inc(tail_ff);
               if (fill_new_cmp >= CMP_W'(high_water)) rts_in = 1'b0;
            end
            rrw_pkg::FUNC_HOLD: begin
               if (nest_ff == '0 && port_ready) rts_in = 1'b0;
               if (nest_ff < rrw_pkg::NEST_MAX) nest_in = nest_ff + 1'b1;
            end
            rrw_pkg::FUNC_RELEASE: begin
               if (nest_ff != '0) begin
                  nest_in = nest_ff - 1'b1;
                  if (nest_ff == 8'd1 && port_ready) rts_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.rd_first) begin
         rd_in    = ram_rdata;
         valid_in = 1'b1;
         head_in  = cnt_inc(head_ff);
      end
      if (cmd.rd_second && ram_rdata == rrw_pkg::PAIR_BYTE) begin
         head_in = cnt_inc(head_ff);
      end
      if (cmd.low_check && nest_ff == '0 && fill_cmp < CMP_W'(low_water)) begin
         rts_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         nest_ff <= '0;
         rts_ff  <= 1'b1;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         nest_ff <= nest_in;
         rts_ff  <= rts_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= in_func;
         byte_ff <= in_rx_byte;
      end
      rd_ff    <= rd_in;
      valid_ff <= valid_in;
      ovf_ff   <= ovf_in;
      if (cmd.load_out) begin
         obyte_ff  <= rd_ff;
         ovalid_ff <= valid_ff;
         orts_ff   <= rts_ff;
         ofill_ff  <= fill_cmp[7:0];
         oovf_ff   <= ovf_ff;
      end
   end

   assign out_read_byte  = obyte_ff;
   assign out_read_valid = ovalid_ff;
   assign out_rts        = orts_ff;
   assign out_fill       = ofill_ff;
   assign out_overflow   = oovf_ff;

   `RRW_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill <= DEPTH_C, "ring fill beyond depth")
   `RRW_ASSERT_IMP(a_head_moves_on_read, clock, reset, !$past(reset) && !$past(cmd.rd_first) && !$past(cmd.rd_second), head_ff == $past(head_ff), "head moved outside a read")
   `RRW_ASSERT_IMP(a_rts_rise_cause, clock, reset, !$past(reset) && $rose(rts_ff), $past(cmd.low_check) || ($past(cmd.exec_op) && $past(func_ff) == rrw_pkg::FUNC_RELEASE), "RTS raised without read or release")

endmodule

@@ sv/rx_ring_with_rts_watermarks_unit.sv @@
// Sequence: a line byte, hold or release is captured, executed and loaded out; a
//   read adds ring reads (none if empty, two for a 0xFF pair) and a low-water check.
// Flow: one word at a time; a new word is taken only in idle, after the previous
//   response loads. Ring reads use the single RAM read port (one byte per cycle).
// Reset: synchronous; pointers and hold nesting clear, RTS asserted, registers
//   return to 16/8/1. Ring RAM contents are not cleared.
// ---------------------------------------------------------------------------
// Receive ring with RTS watermarks
// Top level: CSR port, controller and datapath.
// ---------------------------------------------------------------------------
module rx_ring_with_rts_watermarks_unit #(
   parameter int RING_DEPTH = rrw_pkg::RING_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   rrw_req_if.sink                    req_chan,
   rrw_rsp_if.source                  rsp_chan,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [rrw_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [rrw_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [rrw_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic [7:0]       high_water_ff;
   logic [7:0]       low_water_ff;
   logic             port_ready_ff;
   logic             csr_wr;
   logic [1:0]       csr_idx;
   rrw_pkg::cmd_type cmd;
   rrw_pkg::sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[rrw_pkg::CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         high_water_ff <= rrw_pkg::HIGH_WATER_RST;
         low_water_ff  <= rrw_pkg::LOW_WATER_RST;
         port_ready_ff <= rrw_pkg::PORT_READY_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            rrw_pkg::REG_HIGH_WATER: high_water_ff <= csr_pwdata[7:0];
            rrw_pkg::REG_LOW_WATER:  low_water_ff  <= csr_pwdata[7:0];
            rrw_pkg::REG_PORT_READY: port_ready_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         rrw_pkg::REG_HIGH_WATER: csr_prdata = {24'd0, high_water_ff};
         rrw_pkg::REG_LOW_WATER:  csr_prdata = {24'd0, low_water_ff};
         rrw_pkg::REG_PORT_READY: csr_prdata = {31'd0, port_ready_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   rrw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rrw_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .in_func        (req_chan.func),
      .in_rx_byte     (req_chan.rx_byte),
      .high_water     (high_water_ff),
      .low_water      (low_water_ff),
      .port_ready     (port_ready_ff),
      .out_read_byte  (rsp_chan.read_byte),
      .out_read_valid (rsp_chan.read_valid),
      .out_rts        (rsp_chan.rts_asserted),
      .out_fill       (rsp_chan.fill_level),
      .out_overflow   (rsp_chan.overflow)
   );

endmodule
